// ===== hdl/schroeder_reverb_assert.svh =====
// assertion macros for the schroeder reverb
`ifndef SCHROEDER_REVERB_ASSERT_SVH
`define SCHROEDER_REVERB_ASSERT_SVH
`ifndef SYNTH
`define SR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("schroeder_reverb check failed");
`define SR_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("schroeder_reverb reset check failed");
`else
`define SR_ASSERT(lbl, clk, rst_n, prop)
`define SR_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== hdl/sr_pkg.sv =====
// shared constants and tables of the schroeder reverb
package sr_pkg;

    localparam int NUM_COMBS   = 8;
    localparam int NUM_ALLPASS = 4;
    localparam int CIDX_W      = $clog2(NUM_COMBS);
    localparam int AIDX_W      = $clog2(NUM_ALLPASS);

    localparam int COMB_TOTAL = 11036;
    localparam int AP_TOTAL   = 1598;
    localparam int COMB_AW    = $clog2(COMB_TOTAL);
    localparam int AP_AW      = $clog2(AP_TOTAL);
    localparam int CPOS_W     = 11;
    localparam int APOS_W     = 10;

    localparam int LANE_W = 16;
    localparam int WET_W  = 17;
    localparam logic [WET_W-1:0] WET_ONE   = 17'd65536;
    localparam logic [WET_W-1:0] WET_RESET = 17'd32768;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FB_FIRST = 2'd0,
        CFG_FB_LAST  = 2'd1,
        CFG_WET      = 2'd2
    } cfg_idx_t;

    localparam logic [CPOS_W-1:0] COMB_LEN [NUM_COMBS] =
        '{11'd1119, 11'd1189, 11'd1277, 11'd1357, 11'd1423, 11'd1491, 11'd1559, 11'd1621};
    localparam logic [COMB_AW-1:0] COMB_BASE [NUM_COMBS] =
        '{14'd0, 14'd1119, 14'd2308, 14'd3585, 14'd4942, 14'd6365, 14'd7856, 14'd9415};
    localparam logic [APOS_W-1:0] AP_LEN [NUM_ALLPASS] =
        '{10'd225, 10'd557, 10'd443, 10'd373};
    localparam logic [AP_AW-1:0] AP_BASE [NUM_ALLPASS] =
        '{11'd0, 11'd225, 11'd782, 11'd1225};

endpackage

// ===== hdl/sr_comb_bank.sv =====
// eight feedback combs sharing one delay memory, one comb per cycle
module sr_comb_bank
    import sr_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STORE_WIDTH  = 24,
    parameter int COEF_WIDTH   = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] in_dry,
    input  logic [CFG_DATA_W-1:0]          gain_first,
    input  logic [CFG_DATA_W-1:0]          gain_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_dry,
    output logic signed [STORE_WIDTH-1:0]  out_x
);

    localparam int PW   = STORE_WIDTH + COEF_WIDTH + 1;
    localparam int AW   = ((STORE_WIDTH > SAMPLE_WIDTH) ? STORE_WIDTH : SAMPLE_WIDTH) + 2;
    localparam int SUMW = STORE_WIDTH + CIDX_W;
    localparam logic signed [AW-1:0] ST_HI = AW'((64'sd1 <<< (STORE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] ST_LO = ~ST_HI;
    localparam logic signed [PW-1:0] RND   = PW'(64'sd1 <<< (COEF_WIDTH - 1));

    logic signed [STORE_WIDTH-1:0] mem [COMB_TOTAL];
    logic signed [STORE_WIDTH-1:0] rd_data_reg;

    logic                           have_reg, have_next;
    logic signed [SAMPLE_WIDTH-1:0] dry_in_reg, work_dry_reg;
    logic                           busy_reg, busy_next;
    logic [CIDX_W-1:0]              cnt_reg, cnt_next;
    logic [CPOS_W-1:0]              pos_reg [NUM_COMBS];
    logic [NUM_COMBS-1:0]           wrap_reg;

    logic                 s1_valid_reg, s1_last_reg, s1_live_reg;
    logic [CIDX_W-1:0]    s1_k_reg;
    logic [COMB_AW-1:0]   s1_addr_reg;
    logic                 s2_valid_reg, s2_last_reg;
    logic [COMB_AW-1:0]   s2_addr_reg;
    logic signed [PW-1:0] s2_prod_reg;
    logic signed [SUMW-1:0] sum_reg;

    logic                           res_valid_reg, res_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] res_dry_reg;
    logic signed [STORE_WIDTH-1:0]  res_x_reg;

    logic                          start, issue, last_pos;
    logic [CIDX_W-1:0]             k;
    logic [CPOS_W-1:0]             pos;
    logic [COMB_AW-1:0]            rd_addr;
    logic signed [STORE_WIDTH-1:0] old;
    logic [2*CFG_DATA_W-1:0]       lanes;
    logic [COEF_WIDTH-1:0]         gain;
    logic signed [PW-1:0]          prod, rounded;
    logic signed [AW-1:0]          fb_sum;
    logic signed [STORE_WIDTH-1:0] wr_data;

    assign in_ready  = !have_reg;
    assign out_valid = res_valid_reg;
    assign out_dry   = res_dry_reg;
    assign out_x     = res_x_reg;

    always_comb begin
        start = have_reg && !busy_reg && !s1_valid_reg && !s2_valid_reg &&
                (!res_valid_reg || out_ready);
        issue    = start || busy_reg;
        k        = start ? '0 : cnt_reg;
        pos      = pos_reg[k];
        last_pos = (pos == COMB_LEN[k] - 1'b1);
        rd_addr  = COMB_BASE[k] + COMB_AW'(pos);

        // an entry is only valid once its line has wrapped
        old     = s1_live_reg ? rd_data_reg : '0;
        lanes   = {gain_last, gain_first};
        gain    = lanes[{s1_k_reg, 4'b0000} +: COEF_WIDTH];
        prod    = PW'(old) * $signed(PW'({1'b0, gain}));

        rounded = (s2_prod_reg + RND) >>> COEF_WIDTH;
        fb_sum  = AW'(work_dry_reg) + AW'($signed(rounded[PW-COEF_WIDTH-1:0]));
        if (fb_sum > ST_HI) begin
            wr_data = ST_HI[STORE_WIDTH-1:0];
        end else if (fb_sum < ST_LO) begin
            wr_data = ST_LO[STORE_WIDTH-1:0];
        end else begin
            wr_data = fb_sum[STORE_WIDTH-1:0];
        end

        have_next = have_reg;
        if (in_valid && in_ready) begin
            have_next = 1'b1;
        end else if (start) begin
            have_next = 1'b0;
        end

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CIDX_W'(1);
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CIDX_W'(NUM_COMBS - 1)) begin
                busy_next = 1'b0;
            end
        end

        res_valid_next = res_valid_reg && !out_ready;
        if (s2_valid_reg && s2_last_reg) begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (s2_valid_reg) begin
            mem[s2_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            wrap_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_COMBS; i++) begin
                pos_reg[i] <= '0;
            end
        end else begin
            have_reg      <= have_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            res_valid_reg <= res_valid_next;
            if (issue) begin
                pos_reg[k] <= last_pos ? '0 : pos + 1'b1;
                if (last_pos) begin
                    wrap_reg[k] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            dry_in_reg <= in_dry;
        end
        if (start) begin
            work_dry_reg <= dry_in_reg;
            sum_reg      <= '0;
        end else if (s1_valid_reg) begin
            sum_reg <= sum_reg + SUMW'(old);
        end
        s1_last_reg <= (k == CIDX_W'(NUM_COMBS - 1));
        s1_k_reg    <= k;
        s1_live_reg <= wrap_reg[k];
        s1_addr_reg <= rd_addr;
        s2_last_reg <= s1_last_reg;
        s2_addr_reg <= s1_addr_reg;
        s2_prod_reg <= prod;
        if (s2_valid_reg && s2_last_reg) begin
            res_dry_reg <= work_dry_reg;
            res_x_reg   <= sum_reg[SUMW-1:CIDX_W];
        end
    end

endmodule

// ===== hdl/sr_allpass_chain.sv =====
// four allpass stages in series over one delay memory
module sr_allpass_chain
    import sr_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STORE_WIDTH  = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] in_dry,
    input  logic signed [STORE_WIDTH-1:0]  in_x,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_dry,
    output logic signed [STORE_WIDTH-1:0]  out_y
);

    localparam int EW = STORE_WIDTH + 1;
    localparam logic signed [EW-1:0] ST_HI = EW'((64'sd1 <<< (STORE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] ST_LO = ~ST_HI;

    logic signed [STORE_WIDTH-1:0] mem [AP_TOTAL];
    logic signed [STORE_WIDTH-1:0] rd_data_reg;

    logic                           have_reg, have_next;
    logic signed [SAMPLE_WIDTH-1:0] dry_in_reg, work_dry_reg;
    logic signed [STORE_WIDTH-1:0]  x_in_reg, x_reg;
    logic                           busy_reg, busy_next;
    logic [AIDX_W-1:0]              cnt_reg, cnt_next;
    logic [APOS_W-1:0]              pos_reg [NUM_ALLPASS];
    logic [NUM_ALLPASS-1:0]         wrap_reg;

    logic               s1_valid_reg, s1_last_reg, s1_live_reg;
    logic [AP_AW-1:0]   s1_addr_reg;

    logic                           res_valid_reg, res_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] res_dry_reg;
    logic signed [STORE_WIDTH-1:0]  res_y_reg;

    logic                          start, issue, last_pos;
    logic [AIDX_W-1:0]             k;
    logic [APOS_W-1:0]             pos;
    logic [AP_AW-1:0]              rd_addr;
    logic signed [STORE_WIDTH-1:0] del, y, st;
    logic signed [EW-1:0]          diff, keep;

    assign in_ready  = !have_reg;
    assign out_valid = res_valid_reg;
    assign out_dry   = res_dry_reg;
    assign out_y     = res_y_reg;

    always_comb begin
        start = have_reg && !busy_reg && !s1_valid_reg && (!res_valid_reg || out_ready);
        issue    = start || busy_reg;
        k        = start ? '0 : cnt_reg;
        pos      = pos_reg[k];
        last_pos = (pos == AP_LEN[k] - 1'b1);
        rd_addr  = AP_BASE[k] + AP_AW'(pos);

        del  = s1_live_reg ? rd_data_reg : '0;
        diff = EW'(del) - EW'(x_reg);
        keep = EW'(x_reg) + EW'(del >>> 1);
        if (diff > ST_HI) begin
            y = ST_HI[STORE_WIDTH-1:0];
        end else if (diff < ST_LO) begin
            y = ST_LO[STORE_WIDTH-1:0];
        end else begin
            y = diff[STORE_WIDTH-1:0];
        end
        if (keep > ST_HI) begin
            st = ST_HI[STORE_WIDTH-1:0];
        end else if (keep < ST_LO) begin
            st = ST_LO[STORE_WIDTH-1:0];
        end else begin
            st = keep[STORE_WIDTH-1:0];
        end

        have_next = have_reg;
        if (in_valid && in_ready) begin
            have_next = 1'b1;
        end else if (start) begin
            have_next = 1'b0;
        end

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = AIDX_W'(1);
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == AIDX_W'(NUM_ALLPASS - 1)) begin
                busy_next = 1'b0;
            end
        end

        res_valid_next = res_valid_reg && !out_ready;
        if (s1_valid_reg && s1_last_reg) begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (s1_valid_reg) begin
            mem[s1_addr_reg] <= st;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            wrap_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ALLPASS; i++) begin
                pos_reg[i] <= '0;
            end
        end else begin
            have_reg      <= have_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            s1_valid_reg  <= issue;
            res_valid_reg <= res_valid_next;
            if (issue) begin
                pos_reg[k] <= last_pos ? '0 : pos + 1'b1;
                if (last_pos) begin
                    wrap_reg[k] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            dry_in_reg <= in_dry;
            x_in_reg   <= in_x;
        end
        // stage input chains through x_reg, one stage per cycle
        if (start) begin
            work_dry_reg <= dry_in_reg;
            x_reg        <= x_in_reg;
        end else if (s1_valid_reg) begin
            x_reg <= y;
        end
        s1_last_reg <= (k == AIDX_W'(NUM_ALLPASS - 1));
        s1_live_reg <= wrap_reg[k];
        s1_addr_reg <= rd_addr;
        if (s1_valid_reg && s1_last_reg) begin
            res_dry_reg <= work_dry_reg;
            res_y_reg   <= y;
        end
    end

endmodule

// ===== hdl/schroeder_reverb.sv =====
// Schroeder reverberator: one dry sample in, one mixed sample out per word.
// The comb bank reads and writes its eight delay lines one per cycle through a single
// memory and takes no new sample until the last write of the one before; that loop
// sets the sustained rate. The allpass chain and the two-stage wet/dry mix overlap
// with the comb bank of the next sample. Delay entries are treated as zero until their
// line has wrapped once, so no clearing pass follows reset.
// Configuration words are taken in any cycle and ought to be written only while idle.
`include "schroeder_reverb_assert.svh"
module schroeder_reverb
    import sr_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STORE_WIDTH  = 24,
    parameter int COEF_WIDTH   = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_tdata,  // dry_sample
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       m_tdata,  // mixed_sample
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]                    cfg_index,
    input  logic [CFG_DATA_W-1:0]                   cfg_data
);

    localparam int DW  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int PDW = SAMPLE_WIDTH + WET_W + 1;
    localparam int PYW = STORE_WIDTH + WET_W + 1;
    localparam int TW  = ((SAMPLE_WIDTH > STORE_WIDTH) ? SAMPLE_WIDTH : STORE_WIDTH) + WET_W + 3;
    localparam logic signed [TW-1:0] SM_HI = TW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [TW-1:0] SM_LO = ~SM_HI;
    localparam logic signed [TW-1:0] HALF  = TW'(32768);

    logic [CFG_DATA_W-1:0] fb_first_reg, fb_last_reg;
    logic [WET_W-1:0]      wet_reg;

    logic                           cb_valid, cb_ready;
    logic signed [SAMPLE_WIDTH-1:0] cb_dry;
    logic signed [STORE_WIDTH-1:0]  cb_x;
    logic                           ap_valid, ap_ready;
    logic signed [SAMPLE_WIDTH-1:0] ap_dry;
    logic signed [STORE_WIDTH-1:0]  ap_y;

    logic                           p_valid_reg, p_ready;
    logic signed [PDW-1:0]          pd_reg;
    logic signed [PYW-1:0]          py_reg;
    logic                           o_valid_reg, o_ready;
    logic signed [SAMPLE_WIDTH-1:0] o_data_reg;

    logic [WET_W-1:0]               wet_eff, dry_w;
    logic signed [TW-1:0]           total, shifted;
    logic signed [SAMPLE_WIDTH-1:0] mixed;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_first_reg <= '0;
            fb_last_reg  <= '0;
            wet_reg      <= WET_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FB_FIRST: fb_first_reg <= cfg_data;
                CFG_FB_LAST:  fb_last_reg  <= cfg_data;
                CFG_WET:      wet_reg      <= cfg_data[WET_W-1:0];
                default: ;
            endcase
        end
    end

    sr_comb_bank #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STORE_WIDTH  (STORE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_comb (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_dry     (s_tdata[SAMPLE_WIDTH-1:0]),
        .gain_first (fb_first_reg),
        .gain_last  (fb_last_reg),
        .out_valid  (cb_valid),
        .out_ready  (cb_ready),
        .out_dry    (cb_dry),
        .out_x      (cb_x)
    );

    sr_allpass_chain #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STORE_WIDTH  (STORE_WIDTH)
    ) u_allpass (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cb_valid),
        .in_ready  (cb_ready),
        .in_dry    (cb_dry),
        .in_x      (cb_x),
        .out_valid (ap_valid),
        .out_ready (ap_ready),
        .out_dry   (ap_dry),
        .out_y     (ap_y)
    );

    assign o_ready  = !o_valid_reg || m_tready;
    assign p_ready  = !p_valid_reg || o_ready;
    assign ap_ready = p_ready;

    always_comb begin
        // wet fractions above one count as fully wet
        wet_eff = (wet_reg > WET_ONE) ? WET_ONE : wet_reg;
        dry_w   = WET_ONE - wet_eff;
        total   = TW'(pd_reg) + TW'(py_reg) + HALF;
        shifted = total >>> 16;
        if (shifted > SM_HI) begin
            mixed = SM_HI[SAMPLE_WIDTH-1:0];
        end else if (shifted < SM_LO) begin
            mixed = SM_LO[SAMPLE_WIDTH-1:0];
        end else begin
            mixed = shifted[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (p_ready) begin
                p_valid_reg <= ap_valid;
            end
            if (o_ready) begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ready && ap_valid) begin
            pd_reg <= PDW'(ap_dry) * $signed(PDW'({1'b0, dry_w}));
            py_reg <= PYW'(ap_y) * $signed(PYW'({1'b0, wet_eff}));
        end
        if (o_ready && p_valid_reg) begin
            o_data_reg <= mixed;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = DW'($unsigned(o_data_reg));

    `SR_ASSERT(a_mix_hold, aclk, aresetn, p_valid_reg && !o_ready |=> p_valid_reg)
    `SR_ASSERT(a_out_from_mix, aclk, aresetn, $rose(m_tvalid) |-> $past(p_valid_reg))
    `SR_ASSERT_NORST(a_reset_idle, aclk, !aresetn |=> !m_tvalid && !p_valid_reg)

endmodule

// ===== tb/tb_schroeder_reverb.sv =====
// self-checking testbench of the schroeder reverb: predicted mixed samples against the stream
module tb_schroeder_reverb;
    import sr_pkg::*;

    localparam int SW = 16;
    localparam int STW = 24;
    localparam int CW = 16;
    localparam int LIMIT = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;  // dry_sample
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;       // mixed_sample
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    schroeder_reverb i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // predictor state
    longint comb_mem [COMB_TOTAL];
    int comb_pos [NUM_COMBS];
    longint ap_mem [AP_TOTAL];
    int ap_pos [NUM_ALLPASS];
    logic [63:0] fb_first = '0, fb_last = '0;
    logic [16:0] wet = WET_RESET;

    logic [15:0] pending_dry [$];
    logic [15:0] expected_mix [$];
    int send_idle_pct = 0, recv_idle_pct = 0;
    int hold_cycles = 0;
    bit pause_send = 0;
    int mismatches = 0;
    int cycles = 0;

    function automatic longint floor_shift(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint clip(longint x, int w);
        longint hi, lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        return x > hi ? hi : (x < lo ? lo : x);
    endfunction

    function automatic logic [15:0] reverb_sample(logic [15:0] raw);
        longint dry, sum, x, old, prod, del, y, w, mix, gain;
        int a;
        dry = longint'($signed(raw));
        sum = 0;
        for (int k = 0; k < NUM_COMBS; k++) begin
            a = int'(COMB_BASE[k]) + comb_pos[k];
            old = comb_mem[a];
            gain = (k < 4) ? longint'(fb_first[16*k +: 16]) : longint'(fb_last[16*(k-4) +: 16]);
            prod = floor_shift(old * gain + (longint'(1) << (CW - 1)), CW);
            comb_mem[a] = clip(dry + prod, STW);
            comb_pos[k] = (comb_pos[k] + 1 >= int'(COMB_LEN[k])) ? 0 : comb_pos[k] + 1;
            sum += old;
        end
        x = floor_shift(sum, 3);
        for (int k = 0; k < NUM_ALLPASS; k++) begin
            a = int'(AP_BASE[k]) + ap_pos[k];
            del = ap_mem[a];
            y = clip(del - x, STW);
            ap_mem[a] = clip(x + floor_shift(del, 1), STW);
            ap_pos[k] = (ap_pos[k] + 1 >= int'(AP_LEN[k])) ? 0 : ap_pos[k] + 1;
            x = y;
        end
        w = (wet > WET_ONE) ? 65536 : longint'(wet);
        mix = clip(floor_shift(dry * (65536 - w) + x * w + 32768, 16), SW);
        return mix[15:0];
    endfunction

    // driver
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (s_tvalid && s_tready) begin
            expected_mix.push_back(reverb_sample(s_tdata));
            void'(pending_dry.pop_front());
        end
        if (s_tvalid && !s_tready) begin
            // keep offering the same word
        end else if (aresetn && !pause_send && pending_dry.size() > (s_tvalid && s_tready ? 1 : 0)
                     && $urandom_range(99) >= send_idle_pct) begin
            s_tvalid <= 1'b1;
            s_tdata <= pending_dry[(s_tvalid && s_tready) ? 1 : 0];
        end else begin
            s_tvalid <= 1'b0;
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        logic [15:0] want;
        if (m_tvalid && m_tready) begin
            if (expected_mix.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", m_tdata);
            end else begin
                want = expected_mix.pop_front();
                if (want !== m_tdata) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mixed_sample mismatch: expected %h actual %h", want, m_tdata);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles >= LIMIT) begin
            $display("schroeder_reverb test failed");
            $finish;
        end
    end

    task automatic drain();
        while (pending_dry.size() != 0 || s_tvalid || expected_mix.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FB_FIRST: fb_first = val;
            CFG_FB_LAST: fb_last = val;
            CFG_WET: wet = val[16:0];
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand_gains(int top);
        logic [63:0] g;
        for (int i = 0; i < 4; i++) g[16*i +: 16] = $urandom_range(top);
        return g;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        foreach (comb_mem[i]) comb_mem[i] = 0;
        foreach (ap_mem[i]) ap_mem[i] = 0;
        foreach (comb_pos[i]) comb_pos[i] = 0;
        foreach (ap_pos[i]) ap_pos[i] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: dry half, no feedback
        foreach (s_tdata[b]) begin
            pending_dry.push_back(16'h1 << b);
        end
        pending_dry.push_back(16'h8000);
        pending_dry.push_back(16'h7fff);
        pending_dry.push_back(16'hffff);
        pending_dry.push_back(16'h0000);
        drain();

        // extreme gains, fully wet and above one
        write_reg(CFG_FB_FIRST, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_FB_LAST, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_WET, 64'hffff_ffff_ffff_ffff);
        for (int i = 0; i < 6; i++) pending_dry.push_back(i[0] ? 16'h7fff : 16'h8000);
        drain();
        write_reg(CFG_WET, 64'd65536);
        for (int i = 0; i < 4; i++) pending_dry.push_back(16'h7fff);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 11 : (ph == 1 ? 62 : 0);
            recv_idle_pct = (ph == 0) ? 62 : (ph == 1 ? 11 : 0);
            write_reg(CFG_FB_FIRST, rand_gains(ph == 2 ? 65535 : 60000));
            write_reg(CFG_FB_LAST, rand_gains(65535));
            write_reg(CFG_WET, ph == 1 ? 64'd0 : 64'($urandom_range(65536)));
            for (int i = 0; i < 400; i++) pending_dry.push_back(rand_sample());
            if (ph == 0) begin
                repeat (30) @(posedge aclk);
                hold_cycles = 600;
            end
            if (ph == 1) begin
                while (pending_dry.size() > 200) @(posedge aclk);
                pause_send = 1;
                while (expected_mix.size() != 0 || s_tvalid) @(posedge aclk);
                pause_send = 0;
            end
            drain();
        end

        if (mismatches == 0 && expected_mix.size() == 0) begin
            $display("schroeder_reverb test passed");
        end else begin
            $display("schroeder_reverb test failed");
        end
        $finish;
    end
endmodule
